// File: rtl/ase_pkg.sv
// ---------------------------------------------------------------------------
// ase_pkg: shared types of the array set engine
// Request and response words, the decoded operation and the back-end states.
// ---------------------------------------------------------------------------
package ase_pkg;

   // request codes as carried in req_type
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_ERASE  = 2'd1,
      OP_FIND   = 2'd2,
      OP_CLEAR  = 2'd3
   } ase_op_type;

   // response status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   // width of the count field of a response
   localparam int RSP_COUNT_W = 7;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] value;
   } ase_req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic                   found;
      logic [RSP_COUNT_W-1:0] count;
   } ase_rsp_type;

   // classified command handed from the front end to the back end
   typedef struct packed {
      ase_op_type  op;
      logic [31:0] value;
   } ase_cmd_type;

   // back-end sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_ACT,
      S_SHIFT
   } ase_state_type;

endpackage

// File: rtl/ase_front.sv
// ---------------------------------------------------------------------------
// ase_front: request intake
// Accepts request words, decodes the operation and holds up to two
// commands for the back end.
// ---------------------------------------------------------------------------
module ase_front import ase_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  ase_req_type req_data,
   output logic        cmd_valid,
   output ase_cmd_type cmd,
   input  logic        cmd_pop
);

   ase_cmd_type q_ff [2];
   ase_cmd_type q_in [2];
   logic [1:0]  fill_ff, fill_in;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic        push;
   ase_cmd_type new_cmd;

   // classify the incoming word
   always_comb begin
      new_cmd.op    = ase_op_type'(req_data.req_type);
      new_cmd.value = req_data.value;
   end

   assign busy      = (fill_ff == 2'd2);
   assign push      = start && !busy;
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   // queue pointers and storage
   always_comb begin
      q_in[0]   = q_ff[0];
      q_in[1]   = q_ff[1];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         q_in[wr_ptr_ff] = new_cmd;
         wr_ptr_in       = !wr_ptr_ff;
      end
      if (cmd_pop && cmd_valid) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({push, cmd_pop && cmd_valid})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) begin
         fill_ff   <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

endmodule

// File: rtl/ase_back.sv
// ---------------------------------------------------------------------------
// ase_back: set storage and request sequencer
// Holds the element memory and count, searches the entries one read per
// cycle, compacts after an erase and issues one response per command.
// ---------------------------------------------------------------------------
module ase_back import ase_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  ase_cmd_type cmd,
   output logic        cmd_pop,
   output logic        rsp_valid,
   output ase_rsp_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   // element memory
   logic [31:0]   mem [CAPACITY];
   logic [31:0]   rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          mem_we;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;

   ase_state_type state_ff, state_in;
   ase_cmd_type   cmd_ff, cmd_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic          cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0] cmp_idx_ff, cmp_idx_in;
   logic          found_ff, found_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ase_rsp_type   rsp_ff, rsp_in;

   logic hit;
   logic scan_more;
   logic drained;

   assign hit       = cmp_valid_ff && (rd_data_ff == cmd_ff.value);
   assign scan_more = (scan_ff < count_ff);
   assign drained   = !scan_more && !cmp_valid_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) state_in = S_SEARCH;
         end
         S_SEARCH: begin
            if (hit || drained) state_in = S_ACT;
         end
         S_ACT: begin
            if (cmd_ff.op == OP_ERASE && found_ff) state_in = S_SHIFT;
            else state_in = S_IDLE;
         end
         S_SHIFT: begin
            if (drained) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      rd_addr      = scan_ff[AW-1:0];
      mem_we       = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = cmd_ff.value;
      case (state_ff)
         S_IDLE: begin
            cmd_pop = cmd_valid;
            if (cmd_valid) begin
               cmd_in       = cmd;
               scan_in      = '0;
               cmp_valid_in = 1'b0;
               found_in     = 1'b0;
            end
         end
         // one read issued per cycle, compared the cycle after
         S_SEARCH: begin
            if (hit) begin
               found_in     = 1'b1;
               pos_in       = cmp_idx_ff;
               cmp_valid_in = 1'b0;
            end else if (scan_more) begin
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_ff[AW-1:0];
               scan_in      = scan_ff + 1'b1;
            end else begin
               cmp_valid_in = 1'b0;
            end
         end
         S_ACT: begin
            scan_in      = CW'(pos_ff) + 1'b1;
            cmp_valid_in = 1'b0;
            rsp_in.found = found_ff;
            rsp_in.status = STATUS_OK;
            rsp_valid_in = 1'b1;
            case (cmd_ff.op)
               OP_INSERT: begin
                  if (!found_ff) begin
                     if (count_ff >= CAP_CNT) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
               end
               OP_ERASE: begin
                  if (count_ff == '0) rsp_in.status = STATUS_EMPTY;
                  else if (!found_ff) rsp_in.status = STATUS_NOT_FOUND;
                  else rsp_valid_in = 1'b0;
               end
               OP_FIND: begin
                  if (!found_ff) rsp_in.status = STATUS_NOT_FOUND;
               end
               default: begin
                  count_in = '0;
               end
            endcase
            rsp_in.count = RSP_COUNT_W'(count_in);
         end
         // move each later entry down one place
         S_SHIFT: begin
            if (cmp_valid_ff) begin
               mem_we  = 1'b1;
               wr_addr = cmp_idx_ff - 1'b1;
               wr_data = rd_data_ff;
            end
            if (scan_more) begin
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_ff[AW-1:0];
               scan_in      = scan_ff + 1'b1;
            end else begin
               cmp_valid_in = 1'b0;
            end
            if (drained) begin
               count_in      = count_ff - 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_in.status = STATUS_OK;
               rsp_in.found  = 1'b1;
               rsp_in.count  = RSP_COUNT_W'(count_in);
            end
         end
         default: begin
            cmp_valid_in = 1'b0;
         end
      endcase
   end

   // memory port
   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      scan_ff    <= scan_in;
      cmp_idx_ff <= cmp_idx_in;
      found_ff   <= found_in;
      pos_ff     <= pos_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/array_set_engine_core.sv
// ---------------------------------------------------------------------------
// array_set_engine_core: set of distinct 32-bit values with linear search
// Insert, erase, find and clear on a packed array of CAPACITY entries.
// ---------------------------------------------------------------------------
// Usage:
//  - A request word (req_type, value) is taken on a clock edge with start
//    high and busy low. Up to two requests wait in the intake queue; busy
//    is high while it is full.
//  - Each request gives exactly one response word on rsp_data, marked by a
//    one-cycle rsp_valid strobe. The receiver cannot stall; responses come
//    in request order.
//  - Search: the back end reads one entry per cycle from the element
//    memory, which has one read and one write port, and stops early when
//    the value is hit. An erase that hits is followed by compaction of
//    the later entries on the same memory. Each request is finished
//    before the back end picks up the next one.
//  - Reset empties the set (count to zero) and drops queued requests; the
//    element memory itself is not cleared, entries are read only after
//    being written.
// ---------------------------------------------------------------------------
module array_set_engine_core import ase_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  ase_req_type req_data,
   output logic        rsp_valid,
   output ase_rsp_type rsp_data
);

   logic        cmd_valid;
   logic        cmd_pop;
   ase_cmd_type cmd;

   ase_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   ase_back #(.CAPACITY(CAPACITY)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/ase_checker.sv
// ---------------------------------------------------------------------------
// ase_checker: port-level checks of the array set engine
// Consistency of response words and strobe spacing.
// ---------------------------------------------------------------------------
module ase_checker import ase_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input ase_rsp_type rsp_data
);

   // full status only comes for a value that was absent
   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_FULL |-> !rsp_data.found)
      else $error("full status with found set");

   // empty status only comes with an empty set
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_EMPTY |->
      rsp_data.count == '0 && !rsp_data.found)
      else $error("empty status with nonzero count");

   // not found status never reports the value as present
   a_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_NOT_FOUND |-> !rsp_data.found)
      else $error("not found status with found set");

   // count never exceeds the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_data.count) <= CAPACITY)
      else $error("count above capacity");

   // each request passes through the search and act states, so strobes never come back to back
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back to back response strobes");

endmodule

bind array_set_engine_core ase_checker #(.CAPACITY(CAPACITY)) u_ase_checker (.*);

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for array_set_engine_core
// Request words go in through the start/busy handshake. A set model in the
// bench computes the response of each accepted word, and every rsp_valid
// strobe is checked field by field against the oldest queued response.
// Stimulus: a short directed list, then ~1000 random words in fill, shrink
// and mixed runs with random gaps on the request side.
// ---------------------------------------------------------------------------
module tb_top;
   import ase_pkg::*;

   localparam int SET_CAPACITY = 64;
   localparam int WORD_TARGET  = 1000;  // random request words
   localparam int QUIET_TAIL   = 120;   // last words go out without gaps
   localparam int DRAIN_CYCLES = 200;   // longest search plus compaction

   // backlog entry: a request word, optionally held until all responses are in
   typedef struct packed {
      logic        drain;
      ase_req_type word;
   } set_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   ase_req_type req_data = '0;
   logic        rsp_valid;
   ase_rsp_type rsp_data;

   set_cmd_type req_backlog_q[$];
   ase_rsp_type pending_rsp_q[$];
   logic [31:0] shadow_vals[$];      // generator's view of the set

   // set model state
   logic [31:0] set_vals[SET_CAPACITY];
   int          set_size = 0;

   int issued_cnt   = 0;
   int seen_cnt     = 0;
   int idle_left    = 0;
   int mismatch_cnt = 0;
   int n_words      = 0;

   array_set_engine_core #(.CAPACITY(SET_CAPACITY)) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // set model: apply one request word, return its response
   function automatic ase_rsp_type set_model_apply(input ase_req_type w);
      ase_rsp_type r;
      int          pos;
      logic        hit;
      pos = set_size;
      for (int i = set_size - 1; i >= 0; i--) begin
         if (set_vals[i] == w.value) pos = i;
      end
      hit = (pos < set_size);
      r.status = STATUS_OK;
      case (ase_op_type'(w.req_type))
         OP_INSERT: begin
            if (!hit) begin
               if (set_size >= SET_CAPACITY) begin
                  r.status = STATUS_FULL;
               end else begin
                  set_vals[set_size] = w.value;
                  set_size++;
               end
            end
         end
         OP_ERASE: begin
            if (set_size == 0) begin
               r.status = STATUS_EMPTY;
            end else if (!hit) begin
               r.status = STATUS_NOT_FOUND;
            end else begin
               // compact entries above the hit down by one
               for (int j = pos + 1; j < set_size; j++) set_vals[j-1] = set_vals[j];
               set_size--;
            end
         end
         OP_FIND: begin
            if (!hit) r.status = STATUS_NOT_FOUND;
         end
         default: set_size = 0;
      endcase
      r.found = hit;
      r.count = RSP_COUNT_W'(set_size);
      return r;
   endfunction

   function automatic int shadow_index(input logic [31:0] v);
      for (int i = 0; i < shadow_vals.size(); i++) begin
         if (shadow_vals[i] == v) return i;
      end
      return -1;
   endfunction

   // queue a request word and track the set contents for value picking
   task automatic queue_word(input ase_op_type op, input logic [31:0] v, input logic drain);
      set_cmd_type c;
      int          idx;
      c.drain         = drain;
      c.word.req_type = op;
      c.word.value    = v;
      req_backlog_q.push_back(c);
      n_words++;
      idx = shadow_index(v);
      case (op)
         OP_INSERT: if (idx < 0 && shadow_vals.size() < SET_CAPACITY) shadow_vals.push_back(v);
         OP_ERASE:  if (idx >= 0) shadow_vals.delete(idx);
         OP_CLEAR:  shadow_vals.delete();
         default: ;
      endcase
   endtask

   // value source: a held value, or wide random / narrow range / extremes
   function automatic logic [31:0] pick_value(input bit want_hit);
      int r;
      if (want_hit && shadow_vals.size() > 0)
         return shadow_vals[$urandom_range(0, shadow_vals.size() - 1)];
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom;
      if (r < 85) return 32'($urandom_range(0, 200)) - 32'd100;
      case ($urandom_range(0, 3))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic logic [31:0] fresh_value();
      logic [31:0] v;
      v = pick_value(1'b0);
      while (shadow_index(v) >= 0) v = pick_value(1'b0);
      return v;
   endfunction

   task automatic flag_mismatch(input string what, input ase_rsp_type want,
                                input ase_rsp_type got);
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
         $display("%0t ERROR %s: exp status=%0d found=%0d count=%0d, got status=%0d found=%0d count=%0d",
                  $realtime, what, want.status, want.found, want.count,
                  got.status, got.found, got.count);
   endtask

   // driver: present backlog words, predict on acceptance, insert gaps
   always @(posedge clock) begin
      set_cmd_type nxt;
      logic        drive_next;
      int          idle_pct;
      drive_next = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (rsp_valid) seen_cnt++;
         if (!(start && busy)) begin
            if (start) begin
               pending_rsp_q.push_back(set_model_apply(req_data));
               issued_cnt++;
            end
            // gaps only in two of every three stretches of 150 words
            idle_pct = ((issued_cnt / 150) % 3 == 0) ? 0 : 12;
            if (idle_left > 0) begin
               idle_left--;
            end else if (req_backlog_q.size() > 0) begin
               nxt = req_backlog_q[0];
               if (nxt.drain && issued_cnt != seen_cnt) begin
                  // hold until every outstanding response is back
               end else if (req_backlog_q.size() > QUIET_TAIL &&
                            $urandom_range(0, 99) < idle_pct) begin
                  idle_left = $urandom_range(1, 14) - 1;
               end else begin
                  drive_next = 1'b1;
                  req_data <= nxt.word;
                  void'(req_backlog_q.pop_front());
               end
            end
            start <= drive_next;
         end
      end
   end

   // monitor: check each response strobe against the oldest prediction
   always @(posedge clock) begin
      ase_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp_q.size() == 0) begin
            want = 'x;
            flag_mismatch("response with none outstanding", want, rsp_data);
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_data.status !== want.status || rsp_data.found !== want.found ||
                rsp_data.count !== want.count)
               flag_mismatch("response mismatch", want, rsp_data);
         end
      end
   end

   // stimulus and end of test
   initial begin
      int seg_len;
      int mode;
      int r;
      logic [31:0] v;

      // directed: empty set, extremes, duplicates, erase at first, middle and last position, clear
      queue_word(OP_FIND,   32'h0000_0000, 1'b0);
      queue_word(OP_ERASE,  32'h8000_0000, 1'b0);
      queue_word(OP_CLEAR,  32'h0000_0005, 1'b0);
      queue_word(OP_INSERT, 32'h8000_0000, 1'b0);
      queue_word(OP_INSERT, 32'h7FFF_FFFF, 1'b0);
      queue_word(OP_INSERT, 32'h0000_0000, 1'b0);
      queue_word(OP_INSERT, 32'hFFFF_FFFF, 1'b0);
      queue_word(OP_INSERT, 32'h7FFF_FFFF, 1'b0);
      queue_word(OP_FIND,   32'h8000_0000, 1'b0);
      queue_word(OP_FIND,   32'h0000_0001, 1'b0);
      queue_word(OP_ERASE,  32'h0000_0002, 1'b0);
      queue_word(OP_ERASE,  32'h7FFF_FFFF, 1'b0);
      queue_word(OP_ERASE,  32'hFFFF_FFFF, 1'b0);
      queue_word(OP_ERASE,  32'h8000_0000, 1'b0);
      queue_word(OP_FIND,   32'h7FFF_FFFF, 1'b0);
      queue_word(OP_INSERT, 32'h5555_5555, 1'b0);
      queue_word(OP_INSERT, 32'hAAAA_AAAA, 1'b0);
      queue_word(OP_CLEAR,  32'hAAAA_AAAA, 1'b1);
      queue_word(OP_CLEAR,  32'h0000_0001, 1'b0);
      queue_word(OP_ERASE,  32'h0000_0000, 1'b0);
      queue_word(OP_INSERT, 32'h1234_5678, 1'b1);
      n_words = 0;

      // fill to capacity, then hit the full set from both sides
      while (shadow_vals.size() < SET_CAPACITY) queue_word(OP_INSERT, fresh_value(), 1'b0);
      queue_word(OP_INSERT, fresh_value(), 1'b0);
      queue_word(OP_INSERT, pick_value(1'b1), 1'b0);
      queue_word(OP_ERASE, shadow_vals[SET_CAPACITY-1], 1'b0);
      queue_word(OP_ERASE, shadow_vals[0], 1'b0);

      // random runs: grow, shrink or mixed
      while (n_words < WORD_TARGET) begin
         seg_len = $urandom_range(20, 120);
         mode    = $urandom_range(0, 9);
         for (int k = 0; k < seg_len; k++) begin
            r = $urandom_range(0, 199);
            if (r < 3) begin
               queue_word(OP_CLEAR, pick_value($urandom_range(0, 1)), k == 0);
            end else begin
               r = r / 2;
               if (mode < 5) begin
                  if (r < 65)      queue_word(OP_INSERT, fresh_value(), k == 0 && r < 7);
                  else if (r < 75) queue_word(OP_INSERT, pick_value(1'b1), 1'b0);
                  else if (r < 85) queue_word(OP_FIND, pick_value(r < 80), 1'b0);
                  else if (r < 97) queue_word(OP_ERASE, pick_value(1'b1), 1'b0);
                  else             queue_word(OP_ERASE, pick_value(1'b0), 1'b0);
               end else if (mode < 8) begin
                  if (r < 60)      queue_word(OP_ERASE, pick_value(1'b1), 1'b0);
                  else if (r < 75) queue_word(OP_ERASE, pick_value(1'b0), 1'b0);
                  else if (r < 85) queue_word(OP_FIND, pick_value(r < 80), 1'b0);
                  else if (r < 93) queue_word(OP_INSERT, fresh_value(), 1'b0);
                  else             queue_word(OP_INSERT, pick_value(1'b1), 1'b0);
               end else begin
                  v = pick_value($urandom_range(0, 1));
                  case ($urandom_range(0, 2))
                     0: queue_word(OP_INSERT, v, 1'b0);
                     1: queue_word(OP_ERASE, v, 1'b0);
                     default: queue_word(OP_FIND, v, 1'b0);
                  endcase
               end
            end
         end
      end

      // release reset, then wait for the backlog and all responses
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (req_backlog_q.size() == 0 && start == 1'b0);
      wait (pending_rsp_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0 && pending_rsp_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
